FILE: hw/rtl/aod_pkg.sv
// Package for the accelerometer orientation detector.
// Holds shared widths, reset values, codes, state and command types.
// No dependencies.
`default_nettype none

package aod_pkg;

	localparam int ACCEL_BITS_DEF = 25;
	localparam int STAT_BITS_DEF  = 32;

	localparam int FORCE_W    = 3;
	localparam int CONF_W     = 7;
	localparam int STAB_W     = 16;
	localparam int GRAV_W     = 25;
	localparam int ORIENT_W   = 3;
	localparam int ROT_W      = 2;
	localparam int COUNT_W    = 32;
	localparam int MS_W       = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam int SQ_STEPS   = 3;
	localparam int DIV_STEPS  = 7;

	localparam logic [MS_W-1:0]     MS_SAT      = 17'h10000;
	localparam logic [CONF_W-1:0]   CONF_MAX    = 7'd100;
	localparam logic [CONF_W-1:0]   CONF_MIN    = 7'd10;
	localparam logic [CONF_W-1:0]   CONF_ZERO   = 7'd0;
	localparam logic [FORCE_W-1:0]  FORCE_RESET = 3'b111;
	localparam logic [CONF_W-1:0]   CONF_RESET  = 7'd50;
	localparam logic [STAB_W-1:0]   STAB_RESET  = 16'd500;
	localparam logic [GRAV_W-1:0]   GRAV_RESET  = 25'd500000;

	localparam logic [ORIENT_W-1:0] ORIENT_NORMAL   = 3'd0;
	localparam logic [ORIENT_W-1:0] ORIENT_LEFT     = 3'd1;
	localparam logic [ORIENT_W-1:0] ORIENT_INVERTED = 3'd2;
	localparam logic [ORIENT_W-1:0] ORIENT_RIGHT    = 3'd3;
	localparam logic [ORIENT_W-1:0] ORIENT_UNKNOWN  = 3'd4;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORCE    = 2'd0,
		REG_CONF_THR = 2'd1,
		REG_STAB     = 2'd2,
		REG_GRAV     = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_TICK,
		KIND_FORCED
	} kind_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_CHECK,
		ST_DIVIDE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [FORCE_W-1:0] orient_override;
		logic [CONF_W-1:0]  conf_floor;
		logic [STAB_W-1:0]  settle_ms;
		logic [GRAV_W-1:0]  grav_floor;
	} cfg_t;

	typedef struct packed {
		logic  load;
		kind_t kind;
		logic  sq_en;
		axis_t sq_axis;
		logic  root_step;
		logic  check;
		logic  div_step;
		logic  update;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/aod_cfg.sv
// Configuration register file of the orientation detector.
// Depends on aod_pkg for register indexes, widths and reset values.
`default_nettype none

module aod_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [aod_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [aod_pkg::CFG_DATA_W-1:0] cfg_data,
	output aod_pkg::cfg_t                       cfg
);
	import aod_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orient_override <= FORCE_RESET;
			cfg_q.conf_floor      <= CONF_RESET;
			cfg_q.settle_ms       <= STAB_RESET;
			cfg_q.grav_floor      <= GRAV_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FORCE:    cfg_q.orient_override <= cfg_data[FORCE_W-1:0];
				REG_CONF_THR: cfg_q.conf_floor      <= cfg_data[CONF_W-1:0];
				REG_STAB:     cfg_q.settle_ms       <= cfg_data[STAB_W-1:0];
				REG_GRAV:     cfg_q.grav_floor      <= cfg_data[GRAV_W-1:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/aod_ctrl.sv
// Controller state machine of the orientation detector.
// Sequences squaring, root, check, division and update over the datapath.
// Depends on aod_pkg for state, kind and command types.
`default_nettype none

module aod_ctrl #(
	parameter int ACCEL_BITS = aod_pkg::ACCEL_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             operation,
	input  wire logic             force_sign,
	input  aod_pkg::status_t      status,
	output logic                  in_ready,
	output aod_pkg::cmd_t         cmd
);
	import aod_pkg::*;

	localparam int CNT_W = $clog2(ACCEL_BITS);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	kind_t            kind;

	always_comb begin
		priority if (operation == OP_TICK) begin
			kind = KIND_TICK;
		end else if (!force_sign) begin
			kind = KIND_FORCED;
		end else begin
			kind = KIND_SAMPLE;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					state_d = (kind == KIND_SAMPLE) ? ST_SQUARE : ST_UPDATE;
				end
			end
			ST_SQUARE: begin
				if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_ROOT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ROOT: begin
				if (cnt_q == CNT_W'(ACCEL_BITS - 1)) begin
					cnt_d   = '0;
					state_d = ST_CHECK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CHECK: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_UPDATE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_UPDATE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.kind      = kind;
		cmd.sq_axis   = axis_t'(cnt_q[1:0]);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SQUARE: cmd.sq_en     = 1'b1;
			ST_ROOT:   cmd.root_step = 1'b1;
			ST_CHECK:  cmd.check     = 1'b1;
			ST_DIVIDE: cmd.div_step  = 1'b1;
			ST_UPDATE: cmd.update    = status.out_free;
			default:   cmd.update    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/aod_dp.sv
// Datapath of the orientation detector: squaring multiplier, bit-serial root,
// restoring divider, orientation state and result register.
// Depends on aod_pkg for widths, codes and command types.
`default_nettype none

module aod_dp #(
	parameter int ACCEL_BITS = aod_pkg::ACCEL_BITS_DEF,
	parameter int STAT_BITS  = aod_pkg::STAT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  aod_pkg::cmd_t                      cmd,
	input  aod_pkg::cfg_t                      cfg,
	input  wire logic signed [ACCEL_BITS-1:0]  accel_x,
	input  wire logic signed [ACCEL_BITS-1:0]  accel_y,
	input  wire logic signed [ACCEL_BITS-1:0]  accel_z,
	output aod_pkg::status_t                   status,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [aod_pkg::ORIENT_W-1:0]       orientation,
	output logic                               changed,
	output logic                               report_valid,
	output logic [aod_pkg::ROT_W-1:0]          rotation_code,
	output logic [aod_pkg::CONF_W-1:0]         confidence,
	output logic                               stable,
	output logic [aod_pkg::COUNT_W-1:0]        change_count,
	output logic [aod_pkg::COUNT_W-1:0]        rejected_count
);
	import aod_pkg::*;

	localparam int A  = ACCEL_BITS;
	localparam int SW = 2 * A;
	localparam int DW = A + CONF_W;
	localparam int GW = (A > GRAV_W) ? A : GRAV_W;

	logic [A-1:0]  abs_x, abs_y, abs_z;
	logic [A-1:0]  ax_q, ay_q, az_q;
	logic          xpos_q, ypos_q, zpos_q;
	kind_t         kind_q;
	logic [A-1:0]  sq_op;
	logic [SW-1:0] sq;
	logic [SW-1:0] n_q, res_q, bit_q, root_t;
	logic [A-1:0]  mag;
	logic [A-1:0]  my;
	logic [ORIENT_W-1:0] orient_q;
	logic [A-1:0]  prim_q;
	logic          below_q, magz_q;
	logic [DW-1:0] rem_q, dsor_q;
	logic [CONF_W-1:0] quo_q;

	logic [ORIENT_W-1:0] cur_q;
	logic [MS_W-1:0]     ms_q;
	logic                stable_q;
	logic [CONF_W-1:0]   conf_q;
	logic [STAT_BITS-1:0] chg_q, rej_q;
	logic                out_valid_q;
	logic                changed_q, report_q;
	logic [ROT_W-1:0]    rot_q;

	logic [ORIENT_W-1:0] new_orient;
	logic [CONF_W-1:0]   new_conf;

	assign abs_x = accel_x[A-1] ? ($unsigned(~accel_x) + 1'b1) : $unsigned(accel_x);
	assign abs_y = accel_y[A-1] ? ($unsigned(~accel_y) + 1'b1) : $unsigned(accel_y);
	assign abs_z = accel_z[A-1] ? ($unsigned(~accel_z) + 1'b1) : $unsigned(accel_z);

	always_comb begin
		unique case (cmd.sq_axis)
			AXIS_X:  sq_op = ax_q;
			AXIS_Y:  sq_op = ay_q;
			AXIS_Z:  sq_op = az_q;
			default: sq_op = '0;
		endcase
	end

	assign sq     = SW'(sq_op) * SW'(sq_op);
	assign root_t = res_q + bit_q;
	assign mag    = res_q[A-1:0];
	assign my     = (az_q > ay_q) ? az_q : ay_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q   <= abs_x;
			ay_q   <= abs_y;
			az_q   <= abs_z;
			xpos_q <= !accel_x[A-1] && (accel_x != '0);
			ypos_q <= !accel_y[A-1] && (accel_y != '0);
			zpos_q <= !accel_z[A-1] && (accel_z != '0);
			kind_q <= cmd.kind;
			n_q    <= '0;
			res_q  <= '0;
			bit_q  <= SW'(1) << (SW - 2);
		end
		if (cmd.sq_en) begin
			n_q <= n_q + sq;
			priority if (az_q > ax_q && az_q > ay_q) begin
				orient_q <= zpos_q ? ORIENT_NORMAL : ORIENT_INVERTED;
				prim_q   <= my;
			end else if (ax_q > ay_q) begin
				orient_q <= xpos_q ? ORIENT_LEFT : ORIENT_RIGHT;
				prim_q   <= ax_q;
			end else begin
				orient_q <= ypos_q ? ORIENT_INVERTED : ORIENT_NORMAL;
				prim_q   <= my;
			end
		end
		if (cmd.root_step) begin
			if (n_q >= root_t) begin
				n_q   <= n_q - root_t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.check) begin
			below_q <= GW'(mag) < GW'(cfg.grav_floor);
			magz_q  <= (mag == '0);
			rem_q   <= DW'(prim_q) * DW'(CONF_MAX);
			dsor_q  <= DW'(mag) << (DIV_STEPS - 1);
			quo_q   <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= dsor_q) begin
				rem_q <= rem_q - dsor_q;
				quo_q <= {quo_q[CONF_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[CONF_W-2:0], 1'b0};
			end
			dsor_q <= dsor_q >> 1;
		end
	end

	always_comb begin
		priority if (kind_q == KIND_FORCED) begin
			new_orient = {1'b0, cfg.orient_override[ROT_W-1:0]};
			new_conf   = CONF_MAX;
		end else if (below_q) begin
			new_orient = ORIENT_UNKNOWN;
			new_conf   = CONF_ZERO;
		end else begin
			new_orient = orient_q;
			priority if (magz_q || quo_q < CONF_MIN) begin
				new_conf = CONF_MIN;
			end else if (quo_q > CONF_MAX) begin
				new_conf = CONF_MAX;
			end else begin
				new_conf = quo_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= ORIENT_UNKNOWN;
			ms_q        <= MS_SAT;
			stable_q    <= 1'b0;
			conf_q      <= CONF_ZERO;
			chg_q       <= '0;
			rej_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.update) begin
				if (kind_q == KIND_TICK) begin
					if (ms_q < MS_SAT) begin
						ms_q <= ms_q + 1'b1;
					end
				end else begin
					conf_q <= new_conf;
					if (new_conf < cfg.conf_floor) begin
						rej_q <= rej_q + 1'b1;
					end else if (new_orient != cur_q) begin
						if (ms_q > MS_W'(cfg.settle_ms)) begin
							cur_q    <= new_orient;
							ms_q     <= '0;
							chg_q    <= chg_q + 1'b1;
							stable_q <= 1'b1;
						end else begin
							stable_q <= 1'b0;
						end
					end else begin
						stable_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			changed_q <= 1'b0;
			report_q  <= 1'b0;
			rot_q     <= '0;
			if (kind_q != KIND_TICK && new_conf >= cfg.conf_floor &&
			    new_orient != cur_q && ms_q > MS_W'(cfg.settle_ms)) begin
				changed_q <= 1'b1;
				if (new_orient != ORIENT_UNKNOWN) begin
					report_q <= 1'b1;
					rot_q    <= new_orient[ROT_W-1:0];
				end
			end
		end
	end

	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign orientation    = cur_q;
	assign changed        = changed_q;
	assign report_valid   = report_q;
	assign rotation_code  = rot_q;
	assign confidence     = conf_q;
	assign stable         = stable_q;
	assign change_count   = COUNT_W'(chg_q);
	assign rejected_count = COUNT_W'(rej_q);

endmodule

`default_nettype wire

FILE: hw/rtl/accel_orientation_detector_top.sv
// Accelerometer orientation detector, top level. A sample passes from acceptance
// to a valid result through squaring each axis, one root bit per cycle, a check,
// seven divider steps and an update. A tick or a forced sample goes straight
// from acceptance to the update. Input is accepted again the cycle after the update,
// and an unread result holds the update. Reset restores register defaults and
// unknown orientation.
`default_nettype none

module accel_orientation_detector_top #(
	parameter int ACCEL_BITS = aod_pkg::ACCEL_BITS_DEF,
	parameter int STAT_BITS  = aod_pkg::STAT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           operation,
	input  wire logic signed [ACCEL_BITS-1:0]   accel_x,
	input  wire logic signed [ACCEL_BITS-1:0]   accel_y,
	input  wire logic signed [ACCEL_BITS-1:0]   accel_z,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [aod_pkg::ORIENT_W-1:0]        orientation,
	output logic                                changed,
	output logic                                report_valid,
	output logic [aod_pkg::ROT_W-1:0]           rotation_code,
	output logic [aod_pkg::CONF_W-1:0]          confidence,
	output logic                                stable,
	output logic [aod_pkg::COUNT_W-1:0]         change_count,
	output logic [aod_pkg::COUNT_W-1:0]         rejected_count,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [aod_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [aod_pkg::CFG_DATA_W-1:0] cfg_data
);
	import aod_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	aod_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aod_ctrl #(
		.ACCEL_BITS (ACCEL_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.operation  (operation),
		.force_sign (cfg.orient_override[FORCE_W-1]),
		.status     (status),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	aod_dp #(
		.ACCEL_BITS (ACCEL_BITS),
		.STAT_BITS  (STAT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.status         (status),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.orientation    (orientation),
		.changed        (changed),
		.report_valid   (report_valid),
		.rotation_code  (rotation_code),
		.confidence     (confidence),
		.stable         (stable),
		.change_count   (change_count),
		.rejected_count (rejected_count)
	);

	a_report_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_valid |-> changed && (rotation_code == orientation[ROT_W-1:0]))
		else $error("Reported rotation without a matching orientation change.");

	a_quiet_rotation: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !changed |-> !report_valid && (rotation_code == '0))
		else $error("Rotation reported on a transaction that changed nothing.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input ready while a transaction is still in progress.");

	a_confidence_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> confidence <= CONF_MAX)
		else $error("Confidence above one hundred percent.");

endmodule

`default_nettype wire
